// ===== rtl/psq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types for the sorted priority queue: result status codes and the
// per-cycle command that the top level broadcasts to the cell chain.
// No dependencies.

package psq_pkg;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StFull  = 2'd1,
    StEmpty = 2'd2
  } status_e;

  // Command seen by every cell in the same cycle
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

endpackage

// ===== rtl/psq_cell.sv =====
`timescale 1ns / 1ps
// One storage cell of the sorted chain: holds an element and its priority
// and trades them with its neighbors on push and pop.
// Depends on psq_pkg (cell_ctrl_t).

module psq_cell #(
  parameter int ELEM_WIDTH = 32,
  parameter int PRIO_WIDTH = 8
) (
  input  logic                  clk_i,
  input  psq_pkg::cell_ctrl_t   ctrl_i,
  input  logic                  occ_i,
  input  logic [ELEM_WIDTH-1:0] new_elem_i,
  input  logic [PRIO_WIDTH-1:0] new_prio_i,
  input  logic                  left_keep_i,
  input  logic [ELEM_WIDTH-1:0] left_elem_i,
  input  logic [PRIO_WIDTH-1:0] left_prio_i,
  input  logic [ELEM_WIDTH-1:0] right_elem_i,
  input  logic [PRIO_WIDTH-1:0] right_prio_i,
  output logic                  keep_o,
  output logic [ELEM_WIDTH-1:0] elem_o,
  output logic [PRIO_WIDTH-1:0] prio_o,
  output logic [ELEM_WIDTH-1:0] elem_d_o,
  output logic [PRIO_WIDTH-1:0] prio_d_o
);

  logic [ELEM_WIDTH-1:0] elem_q, elem_d;
  logic [PRIO_WIDTH-1:0] prio_q, prio_d;

  // Entries with strictly higher priority stay; sorted order makes this a prefix
  assign keep_o = occ_i && (prio_q > new_prio_i);

  always_comb begin
    elem_d = elem_q;
    prio_d = prio_q;
    if (ctrl_i.push && !keep_o) begin
      if (left_keep_i) begin
        elem_d = new_elem_i;
        prio_d = new_prio_i;
      end else begin
        elem_d = left_elem_i;
        prio_d = left_prio_i;
      end
    end else if (ctrl_i.pop) begin
      elem_d = right_elem_i;
      prio_d = right_prio_i;
    end
  end

  always_ff @(posedge clk_i) begin
    elem_q <= elem_d;
    prio_q <= prio_d;
  end

  assign elem_o   = elem_q;
  assign prio_o   = prio_q;
  assign elem_d_o = elem_d;
  assign prio_d_o = prio_d;

endmodule

// ===== rtl/priority_stack_queue_core.sv =====
`timescale 1ns / 1ps
// Top level of the sorted priority queue: a chain of psq_cell instances, the
// entry count and a registered result stage. Depends on psq_pkg, psq_cell.
//
//   channel  | dir | tdata (low bit up)                              | tuser
//   s_axis   | in  | elem, prio                                      | mode
//   m_axis   | out | front_elem, front_prio, count, empty_res, status | -
//
// All cells compare against the new priority in parallel and shift in the
// same edge, so one push or pop is accepted per cycle while the result
// register is free. The result is registered and appears in the cycle after acceptance.
// Input is taken while the result register is empty or being drained.
// Reset clears the count and the result valid; cell contents are not reset.

module priority_stack_queue_core #(
  parameter int CAPACITY   = 16,
  parameter int ELEM_WIDTH = 32,
  parameter int PRIO_WIDTH = 8,
  localparam int CntWidth  = $clog2(CAPACITY + 1),
  localparam int InWidth   = ELEM_WIDTH + PRIO_WIDTH,
  localparam int InTWidth  = ((InWidth + 7) / 8) * 8,
  localparam int OutWidth  = ELEM_WIDTH + PRIO_WIDTH + CntWidth + 3,
  localparam int OutTWidth = ((OutWidth + 7) / 8) * 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [InTWidth-1:0]  s_axis_tdata,   // elem, prio, zero pad
  input  logic                 s_axis_tuser,   // mode: 0 push, 1 pop
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutTWidth-1:0] m_axis_tdata    // front_elem, front_prio, count,
                                               // empty_res, status, zero pad
);

  logic [ELEM_WIDTH-1:0] in_elem;
  logic [PRIO_WIDTH-1:0] in_prio;
  logic                  accept;
  logic                  is_full, is_empty;
  psq_pkg::cell_ctrl_t   ctrl;
  psq_pkg::status_e      status;
  logic [CntWidth-1:0]   count_q, count_d;

  logic [ELEM_WIDTH-1:0] cell_elem   [CAPACITY];
  logic [PRIO_WIDTH-1:0] cell_prio   [CAPACITY];
  logic [ELEM_WIDTH-1:0] cell_elem_d [CAPACITY];
  logic [PRIO_WIDTH-1:0] cell_prio_d [CAPACITY];
  logic                  cell_keep   [CAPACITY];

  logic                  out_valid_q;
  logic [ELEM_WIDTH-1:0] out_elem_q;
  logic [PRIO_WIDTH-1:0] out_prio_q;
  logic [CntWidth-1:0]   out_count_q;
  logic                  out_empty_q;
  psq_pkg::status_e      out_status_q;

  assign in_elem = s_axis_tdata[ELEM_WIDTH-1:0];
  assign in_prio = s_axis_tdata[ELEM_WIDTH +: PRIO_WIDTH];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_full       = (count_q == CntWidth'(CAPACITY));
  assign is_empty      = (count_q == '0);

  always_comb begin
    ctrl.push = 1'b0;
    ctrl.pop  = 1'b0;
    status    = psq_pkg::StOk;
    if (accept) begin
      if (!s_axis_tuser) begin
        if (is_full) status = psq_pkg::StFull;
        else         ctrl.push = 1'b1;
      end else begin
        if (is_empty) status = psq_pkg::StEmpty;
        else          ctrl.pop = 1'b1;
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.push)     count_d = count_q + CntWidth'(1);
    else if (ctrl.pop) count_d = count_q - CntWidth'(1);
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                  left_keep;
    logic [ELEM_WIDTH-1:0] left_elem, right_elem;
    logic [PRIO_WIDTH-1:0] left_prio, right_prio;

    // Head cell: the boundary ahead of it counts as a kept entry
    if (i == 0) begin : g_head
      assign left_keep = 1'b1;
      assign left_elem = in_elem;
      assign left_prio = in_prio;
    end else begin : g_link
      assign left_keep = cell_keep[i-1];
      assign left_elem = cell_elem[i-1];
      assign left_prio = cell_prio[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_elem = '0;
      assign right_prio = '0;
    end else begin : g_next
      assign right_elem = cell_elem[i+1];
      assign right_prio = cell_prio[i+1];
    end

    psq_cell #(
      .ELEM_WIDTH(ELEM_WIDTH),
      .PRIO_WIDTH(PRIO_WIDTH)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occ_i        (CntWidth'(i) < count_q),
      .new_elem_i   (in_elem),
      .new_prio_i   (in_prio),
      .left_keep_i  (left_keep),
      .left_elem_i  (left_elem),
      .left_prio_i  (left_prio),
      .right_elem_i (right_elem),
      .right_prio_i (right_prio),
      .keep_o       (cell_keep[i]),
      .elem_o       (cell_elem[i]),
      .prio_o       (cell_prio[i]),
      .elem_d_o     (cell_elem_d[i]),
      .prio_d_o     (cell_prio_d[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept)             out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  // Capture the state after this transaction; zero front when empty
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_count_q  <= count_d;
      out_status_q <= status;
      out_empty_q  <= (count_d == '0);
      out_elem_q   <= (count_d == '0) ? '0 : cell_elem_d[0];
      out_prio_q   <= (count_d == '0) ? '0 : cell_prio_d[0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutTWidth'({out_status_q, out_empty_q, out_count_q,
                                     out_prio_q, out_elem_q});

endmodule

// ===== rtl/psq_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the sorted priority queue, bound to the top level.
// Depends on psq_pkg (status codes) and priority_stack_queue_core ports.

module psq_checker #(
  parameter int CAPACITY   = 16,
  parameter int ELEM_WIDTH = 32,
  parameter int PRIO_WIDTH = 8,
  localparam int CntWidth  = $clog2(CAPACITY + 1),
  localparam int OutTWidth = ((ELEM_WIDTH + PRIO_WIDTH + CntWidth + 3 + 7) / 8) * 8
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [OutTWidth-1:0] m_axis_tdata
);

  localparam int CntLsb = ELEM_WIDTH + PRIO_WIDTH;
  localparam int EmpBit = CntLsb + CntWidth;
  localparam int StLsb  = EmpBit + 1;

  logic [ELEM_WIDTH-1:0] r_elem;
  logic [PRIO_WIDTH-1:0] r_prio;
  logic [CntWidth-1:0]   r_count;
  logic                  r_empty;
  logic [1:0]            r_status;

  assign r_elem   = m_axis_tdata[ELEM_WIDTH-1:0];
  assign r_prio   = m_axis_tdata[ELEM_WIDTH +: PRIO_WIDTH];
  assign r_count  = m_axis_tdata[CntLsb +: CntWidth];
  assign r_empty  = m_axis_tdata[EmpBit];
  assign r_status = m_axis_tdata[StLsb +: 2];

  // Hold a stalled result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (r_empty == (r_count == '0)) && (r_count <= CntWidth'(CAPACITY)))
    else $error("empty flag or count inconsistent");

  a_empty_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && r_empty |-> (r_elem == '0) && (r_prio == '0))
    else $error("front not zero on empty queue");

  a_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ((r_status == psq_pkg::StFull) && (r_count == CntWidth'(CAPACITY))) ||
      ((r_status == psq_pkg::StEmpty) && (r_count == '0)) ||
      (r_status == psq_pkg::StOk))
    else $error("status code does not match count");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result stage");

endmodule

bind priority_stack_queue_core psq_checker #(
  .CAPACITY  (CAPACITY),
  .ELEM_WIDTH(ELEM_WIDTH),
  .PRIO_WIDTH(PRIO_WIDTH)
) u_psq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

// ===== sim/priority_stack_queue_core_tb.sv =====
`timescale 1ns / 1ps
// Testbench for priority_stack_queue_core: directed table plus randomized push/pop
// traffic, checked against a behavioral sorted-queue predictor. Depends on psq_pkg.

module priority_stack_queue_core_tb;

  localparam int Capacity = 16;
  localparam int RandItems = 1700;
  localparam int Drain = 8;
  localparam int Limit = 400000;
  localparam int MaxReports = 10;

  typedef enum logic {
    OpPush = 1'b0,
    OpPop  = 1'b1
  } op_e;

  // Result word as packed in m_axis_tdata, highest field first
  typedef struct packed {
    psq_pkg::status_e status;
    logic             empty_flag;
    logic [4:0]       count;
    logic [7:0]       front_prio;
    logic [31:0]      front_elem;
  } front_report_t;

  typedef struct {
    op_e           op;
    logic [31:0]   elem;
    logic [7:0]    prio;
    bit            typed;
    front_report_t exp;
  } op_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // elem, prio
  logic        s_axis_tuser = 1'b0; // mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // front_elem, front_prio, count, empty_res, status

  priority_stack_queue_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: sorted entries, slot 0 is the front
  logic [31:0]   pq_elem [Capacity];
  logic [7:0]    pq_prio [Capacity];
  int            pq_count = 0;

  front_report_t expected_fronts[$];
  op_row_t       directed_rows[$];

  int  cycle_cnt = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  mismatches = 0;
  int  n_push = 0, n_pop = 0, n_full = 0, n_empty = 0, peak_count = 0;

  function automatic front_report_t make_report(logic [31:0] elem, logic [7:0] prio,
                                                int count, logic empty_flag,
                                                psq_pkg::status_e st);
    front_report_t r;
    r.front_elem = elem;
    r.front_prio = prio;
    r.count      = count[4:0];
    r.empty_flag = empty_flag;
    r.status     = st;
    return r;
  endfunction

  // Apply one push or pop to the predictor and return the queue front after it
  function automatic front_report_t apply_op(op_e op, logic [31:0] elem, logic [7:0] prio);
    int               pos;
    psq_pkg::status_e st;
    st = psq_pkg::StOk;
    if (op == OpPush) begin
      if (pq_count >= Capacity) begin
        st = psq_pkg::StFull;
        n_full++;
      end else begin
        pos = 0;
        while (pos < pq_count && pq_prio[pos] > prio) pos++;
        for (int k = pq_count; k > pos; k--) begin
          pq_elem[k] = pq_elem[k-1];
          pq_prio[k] = pq_prio[k-1];
        end
        pq_elem[pos] = elem;
        pq_prio[pos] = prio;
        pq_count++;
        n_push++;
      end
    end else if (pq_count == 0) begin
      st = psq_pkg::StEmpty;
      n_empty++;
    end else begin
      for (int k = 0; k + 1 < pq_count; k++) begin
        pq_elem[k] = pq_elem[k+1];
        pq_prio[k] = pq_prio[k+1];
      end
      pq_count--;
      n_pop++;
    end
    if (pq_count > peak_count) peak_count = pq_count;
    if (pq_count == 0) return make_report('0, '0, 0, 1'b1, st);
    return make_report(pq_elem[0], pq_prio[0], pq_count, 1'b0, st);
  endfunction

  task automatic add_row(op_e op, logic [31:0] elem, logic [7:0] prio, bit typed,
                         front_report_t exp);
    op_row_t row;
    row.op    = op;
    row.elem  = elem;
    row.prio  = prio;
    row.typed = typed;
    row.exp   = exp;
    directed_rows.push_back(row);
  endtask

  // Drive one transaction; called right after a rising edge
  task automatic send_op(op_e op, logic [31:0] elem, logic [7:0] prio, bit typed,
                         front_report_t exp);
    bit            gaps_on;
    front_report_t pred;
    gaps_on = !(items_sent >= 700 && items_sent < 1000);
    while (gaps_on && $urandom_range(0, 99) < 37) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 40'({$urandom, $urandom});
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {prio, elem};
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pred = apply_op(op, elem, prio);
    expected_fronts.push_back(typed ? exp : pred);
    items_sent++;
  endtask

  // Receiver stall pattern, with a stretch of full throughput
  always @(posedge clk_i) begin
    if (results_seen >= 650 && results_seen < 1050) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= 37);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= Limit) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_cnt,
               expected_fronts.size());
      $display("[priority_stack_queue_core] ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    front_report_t got, exp;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      results_seen++;
      if (expected_fronts.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("unexpected result %h at cycle %0d", got, cycle_cnt);
      end else begin
        exp = expected_fronts.pop_front();
        if (got.front_elem !== exp.front_elem || got.front_prio !== exp.front_prio ||
            got.count !== exp.count || got.empty_flag !== exp.empty_flag ||
            got.status !== exp.status) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display({"result %0d mismatch: elem %h/%h prio %0d/%0d count %0d/%0d ",
                      "empty %b/%b status %0d/%0d (expected/actual)"},
                     results_seen, exp.front_elem, got.front_elem, exp.front_prio,
                     got.front_prio, exp.count, got.count, exp.empty_flag,
                     got.empty_flag, exp.status, got.status);
        end
      end
    end
  end

  initial begin
    int            push_bias;
    op_e           op;
    logic [31:0]   elem;
    logic [7:0]    prio;
    front_report_t none;
    none = '0;

    // Directed rows: empty pop, extreme fields, equal-priority ordering, full refusal
    add_row(OpPop,  32'h0000_0000, 8'd0,   1,
            make_report('0, '0, 0, 1'b1, psq_pkg::StEmpty));
    add_row(OpPush, 32'h8000_0000, 8'd0,   1,
            make_report(32'h8000_0000, 8'd0, 1, 1'b0, psq_pkg::StOk));
    add_row(OpPush, 32'h7fff_ffff, 8'd255, 1,
            make_report(32'h7fff_ffff, 8'd255, 2, 1'b0, psq_pkg::StOk));
    // newest of equal priority goes first
    add_row(OpPush, 32'h0000_0005, 8'd255, 1,
            make_report(32'h0000_0005, 8'd255, 3, 1'b0, psq_pkg::StOk));
    add_row(OpPush, 32'hffff_ffff, 8'd128, 0, none);
    add_row(OpPush, 32'h0000_0000, 8'd128, 0, none);
    add_row(OpPush, 32'h1234_5678, 8'd200, 0, none);
    add_row(OpPush, 32'hdead_beef, 8'd1,   0, none);
    add_row(OpPush, 32'h5555_5555, 8'd128, 0, none);
    add_row(OpPush, 32'haaaa_aaaa, 8'd254, 0, none);
    add_row(OpPush, 32'h0f0f_0f0f, 8'd0,   0, none);
    add_row(OpPush, 32'hf0f0_f0f0, 8'd77,  0, none);
    add_row(OpPush, 32'h0000_0001, 8'd3,   0, none);
    add_row(OpPush, 32'hfedc_ba98, 8'd200, 0, none);
    add_row(OpPush, 32'h0123_4567, 8'd64,  0, none);
    add_row(OpPush, 32'h8765_4321, 8'd128, 0, none);
    add_row(OpPush, 32'h3c3c_3c3c, 8'd1,   0, none);
    add_row(OpPush, 32'h0000_1234, 8'd255, 1,
            make_report(32'h0000_0005, 8'd255, Capacity, 1'b0, psq_pkg::StFull));
    add_row(OpPop,  32'hffff_ffff, 8'd255, 0, none);
    add_row(OpPop,  32'h0000_0000, 8'd0,   0, none);
    add_row(OpPop,  32'h7fff_ffff, 8'd17,  0, none);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_op(directed_rows[i].op, directed_rows[i].elem, directed_rows[i].prio,
              directed_rows[i].typed, directed_rows[i].exp);

    // Alternate fill-heavy, drain-heavy and balanced phases so the queue sweeps
    // between empty and full many times
    for (int n = 0; n < RandItems; n++) begin
      case ((n / 48) % 3)
        0: push_bias = 85;
        1: push_bias = 15;
        default: push_bias = 50;
      endcase
      op = ($urandom_range(0, 99) < push_bias) ? OpPush : OpPop;
      case ($urandom_range(0, 9))
        0: begin
          case ($urandom_range(0, 3))
            0: elem = 32'h8000_0000;
            1: elem = 32'h7fff_ffff;
            2: elem = 32'h0000_0000;
            default: elem = 32'hffff_ffff;
          endcase
        end
        default: elem = $urandom;
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2: prio = 8'($urandom_range(0, 3));          // many ties
        3: prio = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        default: prio = 8'($urandom_range(0, 255));
      endcase
      send_op(op, elem, prio, 0, none);
    end
    s_axis_tvalid <= 1'b0;

    while (expected_fronts.size() != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);

    $display("%0d transactions, %0d results: %0d pushes, %0d pops, %0d full refusals,",
             items_sent, results_seen, n_push, n_pop, n_full);
    $display("%0d empty refusals, peak occupancy %0d of %0d, %0d mismatches",
             n_empty, peak_count, Capacity, mismatches);
    if (mismatches == 0) begin
      $display("[priority_stack_queue_core] OK");
    end else begin
      $display("[priority_stack_queue_core] ERROR");
    end
    $finish;
  end

endmodule
